// ===== src/shpd_pkg.sv =====
package shpd_pkg;

   // Deframer phase codes
   typedef enum logic [2:0] {
      PH_HUNT  = 3'd0,
      PH_CHECK = 3'd1,
      PH_TYPE  = 3'd2,
      PH_LEN   = 3'd3,
      PH_DATA  = 3'd4
   } phase_type;

   localparam logic [7:0] SYNC_RESET = 8'h3c;

   // One result item as held in the output register
   typedef struct packed {
      logic [7:0] packet_kind;
      logic [7:0] payload_byte;
      logic       first_of_packet;
      logic       last_of_packet;
      logic       empty_packet;
      logic       checksum_ok;
   } result_type;

endpackage

// ===== src/sync_header_packet_deframer.sv =====
// Packet deframer for a received serial byte stream. Each input item is one
// byte with its line error flag; an errored byte is dropped as though it never
// arrived. The block hunts for the sync byte (csr_wr_data, reset 0x3c), then
// takes a check byte, a type byte and a length byte. The header passes when the
// check byte's upper nibble equals the low nibble of type plus length; a failed
// header is discarded whole and hunting resumes at the next byte. On a good
// header each payload byte comes out as one result item, flagged first and last
// (rsp_tlast), and the last one carries checksum_ok: payload sum mod 16 against
// the check byte's lower nibble. A zero length header gives one item marked
// empty, first and last at once. Header bytes and bytes consumed while hunting
// give no item. Rate: one item per clock while req_tready is high. The per-byte
// state update is a single combinational step from the state registers to the
// result register; req_tready drops only while the result register is full and
// the sink stalls. An accepted byte's result shows on rsp_tdata in the next cycle.
// Write the sync byte only while the stream is idle.
module sync_header_packet_deframer
   import shpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,   // sync_value

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // [7:0] rx_byte
   input  logic        req_tuser,     // [0] rx_error

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,     // [7:0] payload_byte, [8] first_of_packet,
                                      // [9] checksum_ok, [15:10] zero
   output logic        rsp_tlast,     // last_of_packet
   output logic [8:0]  rsp_tuser      // [7:0] packet_kind, [8] empty_packet
);

   // State registers
   phase_type   phase_ff,       phase_in;
   logic [7:0]  sync_ff;
   logic [7:0]  check_ff,       check_in;
   logic [7:0]  type_ff,        type_in;
   logic [7:0]  left_ff,        left_in;
   logic [3:0]  sum_ff,         sum_in;
   logic        first_ff,       first_in;

   // Output register
   logic        rsp_valid_ff,   rsp_valid_in;
   result_type  rsp_ff,         rsp_in;

   logic        accept;
   logic        emit;
   result_type  result;
   logic [7:0]  left_dec;
   logic [3:0]  sum_add;

   // Take a new item whenever the output slot is free or draining this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign left_dec = left_ff - 8'd1;
   assign sum_add  = sum_ff + req_tdata[3:0];

   always_comb begin
      phase_in = phase_ff;
      check_in = check_ff;
      type_in  = type_ff;
      left_in  = left_ff;
      sum_in   = sum_ff;
      first_in = first_ff;
      emit     = 1'b0;
      result   = '{packet_kind: type_ff, payload_byte: req_tdata,
                   first_of_packet: 1'b0, last_of_packet: 1'b0,
                   empty_packet: 1'b0, checksum_ok: 1'b0};

      if (accept && !req_tuser) begin
         case (phase_ff)
            PH_CHECK: begin
               check_in = req_tdata;
               phase_in = PH_TYPE;
            end
            PH_TYPE: begin
               type_in  = req_tdata;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               if (check_ff[7:4] != (type_ff[3:0] + req_tdata[3:0])) begin
                  // bad header: drop all four bytes
                  phase_in = PH_HUNT;
               end else if (req_tdata == 8'd0) begin
                  phase_in               = PH_HUNT;
                  emit                   = 1'b1;
                  result.payload_byte    = 8'd0;
                  result.first_of_packet = 1'b1;
                  result.last_of_packet  = 1'b1;
                  result.empty_packet    = 1'b1;
                  result.checksum_ok     = (check_ff[3:0] == 4'd0);
               end else begin
                  left_in  = req_tdata;
                  sum_in   = 4'd0;
                  first_in = 1'b1;
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               sum_in                 = sum_add;
               left_in                = left_dec;
               first_in               = 1'b0;
               emit                   = 1'b1;
               result.first_of_packet = first_ff;
               result.last_of_packet  = (left_dec == 8'd0);
               result.checksum_ok     = (left_dec == 8'd0) && (check_ff[3:0] == sum_add);
               if (left_dec == 8'd0) begin
                  phase_in = PH_HUNT;
               end
            end
            default: begin
               // hunting, and any unused code behaves as hunting
               phase_in = (req_tdata == sync_ff) ? PH_CHECK : PH_HUNT;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (accept && emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         sync_ff      <= SYNC_RESET;
         check_ff     <= 8'd0;
         type_ff      <= 8'd0;
         left_ff      <= 8'd0;
         sum_ff       <= 4'd0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         check_ff     <= check_in;
         type_ff      <= type_in;
         left_ff      <= left_in;
         sum_ff       <= sum_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            sync_ff <= csr_wr_data;
         end
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ff.checksum_ok, rsp_ff.first_of_packet,
                        rsp_ff.payload_byte};
   assign rsp_tlast  = rsp_ff.last_of_packet;
   assign rsp_tuser  = {rsp_ff.empty_packet, rsp_ff.packet_kind};

`ifndef SYNTHESIS
   // an empty packet is a whole packet on its own
   a_empty_first_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_ff.empty_packet |-> rsp_ff.first_of_packet && rsp_tlast)
      else $error("empty packet item not marked first and last");

   // payload phase always has bytes still to come
   a_data_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> left_ff != 8'd0)
      else $error("payload phase with zero bytes left");

   // an errored byte leaves the deframer where it was
   a_error_hold: assert property (@(posedge clock) disable iff (reset)
      accept && req_tuser |=> phase_ff == $past(phase_ff) && left_ff == $past(left_ff))
      else $error("errored byte changed deframer state");

   // checksum flag only on the last item of a packet
   a_ok_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !rsp_ff.checksum_ok)
      else $error("checksum_ok set on an item that is not last");
`endif

endmodule
